@@ rtl/osbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osbc_pkg: shared definitions for the overlap-save block convolver
// Widths, request and register codes, and the control word sent to the cells.
// ----------------------------------------------------------------------------
package osbc_pkg;

  localparam int MAX_BLOCK_DEF   = 64;
  localparam int MAX_TAPS_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int IN_W      = 16;  // value_real / value_imag port width
  localparam int OUT_W     = 39;  // y_real / y_imag width, sums wrap here
  localparam int CFG_W     = 7;   // tap_count / block_length width
  localparam int CFG_IDX_W = 2;   // config register index width
  localparam int TAP_IDX_W = 6;
  localparam int POS_W     = 6;

  localparam logic [CFG_W-1:0] RESET_TAP_COUNT    = 7'd1;
  localparam logic [CFG_W-1:0] RESET_BLOCK_LENGTH = 7'd64;

  localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd1;

  typedef enum logic [1:0] {
    REQ_TAP     = 2'd0,
    REQ_SAMPLE  = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  // Control word broadcast to every cell of the tap chain.
  typedef struct packed {
    logic                 adv;        // chain advances this cycle
    logic                 clr;        // zero products and partial sums
    logic                 run;        // a replayed sample is on the bus
    logic                 tap_we;     // tap load
    logic [TAP_IDX_W-1:0] tap_idx;
    logic [CFG_W-1:0]     taps_used;  // effective M
  } ctl_t;

endpackage

@@ rtl/osbc_line.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osbc_line: sample history shift line
// Newest sample at slot 0. Rotating DEPTH times replays the history oldest
// first and leaves the line as it was.
// ----------------------------------------------------------------------------
module osbc_line import osbc_pkg::*; #(
  parameter int DEPTH       = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clear_i,
  input  logic                          shift_i,
  input  logic                          rotate_i,
  input  logic signed [SAMPLE_BITS-1:0] din_re_i,
  input  logic signed [SAMPLE_BITS-1:0] din_im_i,
  output logic signed [SAMPLE_BITS-1:0] oldest_re_o,
  output logic signed [SAMPLE_BITS-1:0] oldest_im_o
);

  logic [2*SAMPLE_BITS-1:0] slot_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) slot_q[i] <= '0;
    end else if (clear_i) begin
      for (int i = 0; i < DEPTH; i++) slot_q[i] <= '0;
    end else if (shift_i || rotate_i) begin
      for (int i = 1; i < DEPTH; i++) slot_q[i] <= slot_q[i-1];
      slot_q[0] <= shift_i ? {din_re_i, din_im_i} : slot_q[DEPTH-1];
    end
  end

  assign oldest_re_o = slot_q[DEPTH-1][2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign oldest_im_o = slot_q[DEPTH-1][SAMPLE_BITS-1:0];

endmodule

@@ rtl/osbc_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osbc_cell: one tap of the transposed-form complex FIR chain
// Holds tap IDX, registers its product with the broadcast sample, and adds
// it to the partial sum handed down from the next cell.
// ----------------------------------------------------------------------------
module osbc_cell import osbc_pkg::*; #(
  parameter int IDX         = 0,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctl_t                          ctl_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_re_i,
  input  logic signed [SAMPLE_BITS-1:0] tap_im_i,
  input  logic signed [SAMPLE_BITS-1:0] x_re_i,
  input  logic signed [SAMPLE_BITS-1:0] x_im_i,
  input  logic signed [OUT_W-1:0]       acc_re_i,
  input  logic signed [OUT_W-1:0]       acc_im_i,
  output logic signed [OUT_W-1:0]       acc_re_o,
  output logic signed [OUT_W-1:0]       acc_im_o
);

  localparam int PW = 2 * SAMPLE_BITS + 1;

  logic signed [SAMPLE_BITS-1:0] h_re_q, h_im_q;
  logic signed [OUT_W-1:0]       prod_re_q, prod_im_q, prod_re_d, prod_im_d;
  logic signed [OUT_W-1:0]       acc_re_q, acc_im_q;
  logic signed [PW-1:0]          mul_re, mul_im;
  logic                          used;

  assign used = CFG_W'(IDX) < ctl_i.taps_used;

  always_comb begin
    mul_re = h_re_q * x_re_i - h_im_q * x_im_i;
    mul_im = h_re_q * x_im_i + h_im_q * x_re_i;
    if (ctl_i.run && used) begin
      prod_re_d = OUT_W'(mul_re);
      prod_im_d = OUT_W'(mul_im);
    end else begin
      prod_re_d = '0;
      prod_im_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_re_q <= '0;
      h_im_q <= '0;
    end else if (ctl_i.tap_we && (ctl_i.tap_idx == TAP_IDX_W'(IDX))) begin
      h_re_q <= tap_re_i;
      h_im_q <= tap_im_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_re_q <= '0;
      prod_im_q <= '0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
    end else if (ctl_i.clr) begin
      prod_re_q <= '0;
      prod_im_q <= '0;
      acc_re_q  <= '0;
      acc_im_q  <= '0;
    end else if (ctl_i.adv) begin
      prod_re_q <= prod_re_d;
      prod_im_q <= prod_im_d;
      acc_re_q  <= prod_re_q + acc_re_i;
      acc_im_q  <= prod_im_q + acc_im_i;
    end
  end

  assign acc_re_o = acc_re_q;
  assign acc_im_o = acc_im_q;

endmodule

@@ rtl/overlap_save_block_convolver_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_save_block_convolver_core: overlap-save complex block convolver
// Collects blocks of B = L-M+1 samples and, per block, emits the B exact
// (unrounded) outputs of the complex M-tap filter over the L-sample window.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake             | word
//  --------+-----+-----------------------+-----------------------------------
//  in      | in  | in_valid/in_ready     | req_type, tap_index, value_re/im
//  out     | out | out_valid/out_ready   | y_real, y_imag, out_position, last
//  cfg     | in  | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
//  Replay: tap loads, restarts and samples that do not close a block leave
//  the block idle. The sample that closes a block starts a replay of the
//  MAX_BLOCK-deep history line through the tap chain, oldest sample first,
//  and on through the product and sum registers; in_ready is low for the
//  whole replay. The B outputs are the last B sums that the replay yields.
//  Stalls: while the output register holds a word that is not taken, the
//  whole chain and the replay counter freeze.
//  Reset: taps, history and fill go to zero, tap_count to 1, block_length
//  to 64. No clearing pass. cfg_ready is always high.
//
//  The history line keeps every recent sample, not only the window: samples
//  older than the window reach only outputs before window position M-1,
//  which are never emitted, so a full-depth replay gives the right sums.
// ----------------------------------------------------------------------------
module overlap_save_block_convolver_core import osbc_pkg::*; #(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int MAX_TAPS    = MAX_TAPS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // input words
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              req_type_i,
  input  logic [TAP_IDX_W-1:0]    tap_index_i,
  input  logic signed [IN_W-1:0]  value_real_i,
  input  logic signed [IN_W-1:0]  value_imag_i,
  // output words
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] y_real_o,
  output logic signed [OUT_W-1:0] y_imag_o,
  output logic [POS_W-1:0]        out_position_o,
  output logic                    last_of_block_o,
  // configuration writes
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_W-1:0]        cfg_data_i
);

  localparam int LIM   = (MAX_TAPS < MAX_BLOCK) ? MAX_TAPS : MAX_BLOCK;
  localparam int CNT_W = $clog2(MAX_BLOCK + 2);
  localparam int SUM_W = $clog2(2 * MAX_BLOCK + 3);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  // --------------------------------------------------------------------------
  // Configuration registers and effective M, L, B
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] tap_count_q, block_length_q;
  logic [CFG_W-1:0] m_eff, l_eff, b_eff;
  logic             cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign cfg_hit = cfg_valid_i &&
                   (cfg_index_i == REG_TAP_COUNT || cfg_index_i == REG_BLOCK_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q    <= RESET_TAP_COUNT;
      block_length_q <= RESET_BLOCK_LENGTH;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_TAP_COUNT) tap_count_q <= cfg_data_i;
      if (cfg_index_i == REG_BLOCK_LENGTH) block_length_q <= cfg_data_i;
    end
  end

  // clamp M to 1..LIM, L to 2..MAX_BLOCK then at least M
  always_comb begin
    m_eff = tap_count_q;
    if (m_eff < CFG_W'(1)) m_eff = CFG_W'(1);
    if (m_eff > CFG_W'(LIM)) m_eff = CFG_W'(LIM);
    l_eff = block_length_q;
    if (l_eff < CFG_W'(2)) l_eff = CFG_W'(2);
    if (l_eff > CFG_W'(MAX_BLOCK)) l_eff = CFG_W'(MAX_BLOCK);
    if (l_eff < m_eff) l_eff = m_eff;
    b_eff = l_eff - m_eff + CFG_W'(1);
  end

  // --------------------------------------------------------------------------
  // Input decode; values keep their low SAMPLE_BITS bits as two's complement
  // --------------------------------------------------------------------------
  logic                          in_acc, is_tap, is_sample, is_restart;
  logic [2*IN_W-1:0]             re_ext, im_ext;
  logic signed [SAMPLE_BITS-1:0] samp_re, samp_im;

  assign in_acc = in_valid_i && in_ready_o;
  assign re_ext = {{IN_W{1'b0}}, value_real_i};
  assign im_ext = {{IN_W{1'b0}}, value_imag_i};
  assign samp_re = re_ext[SAMPLE_BITS-1:0];
  assign samp_im = im_ext[SAMPLE_BITS-1:0];

  always_comb begin
    is_tap     = 1'b0;
    is_sample  = 1'b0;
    is_restart = 1'b0;
    case (req_e'(req_type_i))
      REQ_TAP:     is_tap     = in_acc;
      REQ_SAMPLE:  is_sample  = in_acc;
      REQ_RESTART: is_restart = in_acc;
      default:     ;  // code 3: dropped
    endcase
  end

  // --------------------------------------------------------------------------
  // Block fill and replay sequencer
  // --------------------------------------------------------------------------
  state_e           state_q, state_d;
  logic [CFG_W-1:0] fill_q, fill_d, fill_inc;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             blk_done, adv, run, emit;

  assign fill_inc   = fill_q + CFG_W'(1);
  assign blk_done   = is_sample && (fill_inc >= b_eff);
  assign in_ready_o = (state_q == ST_IDLE);

  // chain moves unless a finished word sits unread
  assign adv = !out_valid_o || out_ready_i;
  assign run = (state_q == ST_RUN) && (cnt_q < CNT_W'(MAX_BLOCK));
  // cell 0 holds the output for replay step cnt-2; keep the last B of them
  assign emit = (state_q == ST_RUN) &&
                (SUM_W'(cnt_q) + SUM_W'(b_eff) >= SUM_W'(MAX_BLOCK + 2));

  always_comb begin
    fill_d  = fill_q;
    state_d = state_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    if (cfg_hit || is_restart) begin
      fill_d = '0;
    end else if (is_sample) begin
      fill_d = blk_done ? '0 : fill_inc;
    end
    case (state_q)
      ST_IDLE: begin
        if (blk_done) begin
          state_d = ST_RUN;
          cnt_d   = '0;
          pos_d   = '0;
        end
      end
      ST_RUN: begin
        if (adv) begin
          cnt_d = cnt_q + CNT_W'(1);
          if (emit) pos_d = pos_q + POS_W'(1);
          if (cnt_q == CNT_W'(MAX_BLOCK + 1)) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      cnt_q   <= '0;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
    end
  end

  // --------------------------------------------------------------------------
  // History line and tap chain
  // --------------------------------------------------------------------------
  logic signed [SAMPLE_BITS-1:0] x_re, x_im;
  logic signed [OUT_W-1:0]       acc_re_w [MAX_TAPS+1];
  logic signed [OUT_W-1:0]       acc_im_w [MAX_TAPS+1];
  ctl_t                          ctl;

  osbc_line #(
    .DEPTH       (MAX_BLOCK),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_line (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (cfg_hit || is_restart),
    .shift_i     (is_sample),
    .rotate_i    (adv && run),
    .din_re_i    (samp_re),
    .din_im_i    (samp_im),
    .oldest_re_o (x_re),
    .oldest_im_o (x_im)
  );

  always_comb begin
    ctl.adv       = adv;
    ctl.clr       = blk_done;  // fresh sums for each replay
    ctl.run       = run;
    ctl.tap_we    = is_tap;
    ctl.tap_idx   = tap_index_i;
    ctl.taps_used = m_eff;
  end

  assign acc_re_w[MAX_TAPS] = '0;
  assign acc_im_w[MAX_TAPS] = '0;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    osbc_cell #(
      .IDX         (k),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctl_i    (ctl),
      .tap_re_i (samp_re),
      .tap_im_i (samp_im),
      .x_re_i   (x_re),
      .x_im_i   (x_im),
      .acc_re_i (acc_re_w[k+1]),
      .acc_im_i (acc_im_w[k+1]),
      .acc_re_o (acc_re_w[k]),
      .acc_im_o (acc_im_w[k])
    );
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic                    out_valid_q;
  logic signed [OUT_W-1:0] y_re_q, y_im_q;
  logic [POS_W-1:0]        out_pos_q;
  logic                    out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && emit) begin
      y_re_q     <= acc_re_w[0];
      y_im_q     <= acc_im_w[0];
      out_pos_q  <= pos_q;
      out_last_q <= (CFG_W'(pos_q) + CFG_W'(1)) == b_eff;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign y_real_o        = y_re_q;
  assign y_imag_o        = y_im_q;
  assign out_position_o  = out_pos_q;
  assign last_of_block_o = out_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // the final step of a replay loads the word flagged last
  a_last_ends_replay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && adv && cnt_q == CNT_W'(MAX_BLOCK + 1))
      |=> (state_q == ST_IDLE && out_valid_o && last_of_block_o))
    else $error("replay ended without a last word");

  // fill never reaches B between blocks
  a_fill_below_b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (fill_q < b_eff))
    else $error("block fill out of range");

  // replay counter stays inside its run
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= CNT_W'(MAX_BLOCK + 1)))
    else $error("replay counter overrun");

  // a stalled output freezes the replay
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN && out_valid_o && !out_ready_i) |=> $stable(cnt_q))
    else $error("replay moved under a stall");

endmodule

@@ test/overlap_save_block_convolver_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overlap_save_block_convolver_core_tb: self-checking bench for the convolver
// Walks a short table of hand-picked words, then streams random sample blocks
// under several tap/block settings and three pacing mixes. Every output word
// is compared field by field with the in-bench overlap-save model or a typed table row.
// ----------------------------------------------------------------------------
module overlap_save_block_convolver_core_tb;
  import osbc_pkg::*;

  localparam int HOLD_CYCLES  = MAX_BLOCK_DEF + 8;  // block replay plus margin
  localparam int STALL_LIMIT  = 4000;               // cycles with no handshake
  localparam int PHASE_WORDS  = 112;
  localparam int MAX_PRINTED  = 40;

  // Codes the package does not name: the spare request and the spare register.
  localparam logic [1:0]           REQ_UNKNOWN = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  typedef struct {
    logic signed [OUT_W-1:0] y_re;
    logic signed [OUT_W-1:0] y_im;
    logic [POS_W-1:0]        pos;
    logic                    last_flag;
  } conv_out_t;

  typedef enum {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [1:0]              req;
    logic [TAP_IDX_W-1:0]    idx;
    logic signed [IN_W-1:0]  v_re;
    logic signed [IN_W-1:0]  v_im;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_W-1:0]        reg_data;
    bit                      typed;     // expected word written in the table
    conv_out_t               want;
  } stim_row_t;

  // DUT ports
  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic [1:0]              req_type_i = '0;
  logic [TAP_IDX_W-1:0]    tap_index_i = '0;
  logic signed [IN_W-1:0]  value_real_i = '0;
  logic signed [IN_W-1:0]  value_imag_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [OUT_W-1:0] y_real_o;
  logic signed [OUT_W-1:0] y_imag_o;
  logic [POS_W-1:0]        out_position_o;
  logic                    last_of_block_o;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_W-1:0]        cfg_data_i = '0;

  overlap_save_block_convolver_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .tap_index_i    (tap_index_i),
    .value_real_i   (value_real_i),
    .value_imag_i   (value_imag_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .y_real_o       (y_real_o),
    .y_imag_o       (y_imag_o),
    .out_position_o (out_position_o),
    .last_of_block_o(last_of_block_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Model state: taps, window history, fill count and the two registers.
  // --------------------------------------------------------------------------
  logic signed [IN_W-1:0] tap_re [MAX_TAPS_DEF];
  logic signed [IN_W-1:0] tap_im [MAX_TAPS_DEF];
  logic signed [IN_W-1:0] win_re [MAX_BLOCK_DEF];
  logic signed [IN_W-1:0] win_im [MAX_BLOCK_DEF];
  int unsigned            fill_cnt;
  logic [CFG_W-1:0]       tap_count_reg;
  logic [CFG_W-1:0]       block_len_reg;

  conv_out_t pending_outputs[$];   // words the DUT still owes, oldest first
  stim_row_t stim_rows[$];

  int mismatches   = 0;
  int in_words     = 0;
  int sample_words = 0;
  int out_words    = 0;
  int cfg_writes   = 0;
  int idle_cycles  = 0;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;

  function automatic int unsigned taps_in_use();
    int unsigned m;
    m = tap_count_reg;
    if (m < 1) m = 1;
    if (m > MAX_TAPS_DEF) m = MAX_TAPS_DEF;
    if (m > MAX_BLOCK_DEF) m = MAX_BLOCK_DEF;
    return m;
  endfunction

  function automatic int unsigned window_len(input int unsigned m);
    int unsigned l;
    l = block_len_reg;
    if (l < 2) l = 2;
    if (l > MAX_BLOCK_DEF) l = MAX_BLOCK_DEF;
    if (l < m) l = m;
    return l;
  endfunction

  task automatic clear_window();
    for (int j = 0; j < MAX_BLOCK_DEF; j++) begin
      win_re[j] = '0;
      win_im[j] = '0;
    end
    fill_cnt = 0;
  endtask

  // Applies one accepted input word; a block-closing sample queues B outputs.
  task automatic convolve_word(input logic [1:0] req, input logic [TAP_IDX_W-1:0] idx,
                               input logic signed [IN_W-1:0] v_re,
                               input logic signed [IN_W-1:0] v_im);
    int unsigned m, l, b;
    longint      acc_re, acc_im;
    conv_out_t   res;
    case (req)
      REQ_TAP: begin
        tap_re[idx] = v_re;
        tap_im[idx] = v_im;
      end
      REQ_RESTART: clear_window();
      REQ_SAMPLE: begin
        m = taps_in_use();
        l = window_len(m);
        b = l - m + 1;
        if (fill_cnt >= b) fill_cnt = 0;
        win_re[m - 1 + fill_cnt] = v_re;
        win_im[m - 1 + fill_cnt] = v_im;
        fill_cnt++;
        if (fill_cnt == b) begin
          for (int unsigned n = m - 1; n < l; n++) begin
            acc_re = 0;
            acc_im = 0;
            for (int unsigned k = 0; k < m; k++) begin
              acc_re += longint'(tap_re[k]) * longint'(win_re[n - k])
                      - longint'(tap_im[k]) * longint'(win_im[n - k]);
              acc_im += longint'(tap_re[k]) * longint'(win_im[n - k])
                      + longint'(tap_im[k]) * longint'(win_re[n - k]);
            end
            res.y_re      = acc_re[OUT_W-1:0];
            res.y_im      = acc_im[OUT_W-1:0];
            res.pos       = POS_W'(n - (m - 1));
            res.last_flag = (n == l - 1);
            pending_outputs.push_back(res);
          end
          // last M-1 window samples become the next block's history
          for (int unsigned j = 0; j + 1 < m; j++) begin
            win_re[j] = win_re[l - (m - 1) + j];
            win_im[j] = win_im[l - (m - 1) + j];
          end
          fill_cnt = 0;
        end
      end
      default: ;  // spare request code: no effect
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint want, input longint got);
    if (mismatches < MAX_PRINTED)
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_output();
    conv_out_t want;
    if (pending_outputs.size() == 0) begin
      report_mismatch("output word with none expected, y_real", 0, y_real_o);
    end else begin
      want = pending_outputs.pop_front();
      if (y_real_o !== want.y_re) report_mismatch("y_real", want.y_re, y_real_o);
      if (y_imag_o !== want.y_im) report_mismatch("y_imag", want.y_im, y_imag_o);
      if (out_position_o !== want.pos)
        report_mismatch("out_position", want.pos, out_position_o);
      if (last_of_block_o !== want.last_flag)
        report_mismatch("last_of_block", want.last_flag, last_of_block_o);
    end
  endtask

  // Output side: sample the word at the edge, then pick next cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      check_output();
      out_words++;
    end
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Watchdog: any accepted word on any channel resets the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
          $display("Timeout after %0d cycles without a handshake", STALL_LIMIT);
          $display("Mismatches found");
          $finish;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  // Presents one input word after a random gap and waits for its acceptance.
  // Valid is left high: the next call either idles it or reloads the word.
  task automatic send_word(input logic [1:0] req, input logic [TAP_IDX_W-1:0] idx,
                           input logic signed [IN_W-1:0] v_re,
                           input logic signed [IN_W-1:0] v_im);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    tap_index_i  <= idx;
    value_real_i <= v_re;
    value_imag_i <= v_im;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    convolve_word(req, idx, v_re, v_im);
    in_words++;
    if (req == REQ_SAMPLE) sample_words++;
  endtask

  // Register writes only land on an idle block: drain, let the replay finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_idx, input logic [CFG_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= reg_idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (reg_idx == REG_TAP_COUNT) begin
      tap_count_reg = data;
      clear_window();
    end else if (reg_idx == REG_BLOCK_LENGTH) begin
      block_len_reg = data;
      clear_window();
    end
    cfg_writes++;
  endtask

  // Mostly uniform, with the corner values of Q1.15 now and then.
  function automatic logic signed [IN_W-1:0] rand_value();
    logic signed [IN_W-1:0] v;
    v = IN_W'($urandom);
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 3))
        0: v = -16'sd32768;
        1: v = 16'sd32767;
        2: v = '0;
        default: v = -16'sd1;
      endcase
    end
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  task automatic add_cfg(input logic [CFG_IDX_W-1:0] reg_idx, input logic [CFG_W-1:0] data);
    stim_row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.kind     = ROW_CFG;
    r.reg_idx  = reg_idx;
    r.reg_data = data;
    stim_rows.push_back(r);
  endtask

  task automatic add_word(input logic [1:0] req, input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [IN_W-1:0] v_re,
                          input logic signed [IN_W-1:0] v_im);
    stim_row_t r;
    r = '{kind: ROW_WORD, default: '0};
    r.kind = ROW_WORD;
    r.req  = req;
    r.idx  = idx;
    r.v_re = v_re;
    r.v_im = v_im;
    stim_rows.push_back(r);
  endtask

  // A sample that closes a one-output block, with its output written out.
  task automatic add_checked(input logic signed [IN_W-1:0] v_re,
                             input logic signed [IN_W-1:0] v_im,
                             input logic signed [OUT_W-1:0] y_re,
                             input logic signed [OUT_W-1:0] y_im);
    add_word(REQ_SAMPLE, '0, v_re, v_im);
    stim_rows[stim_rows.size() - 1].typed = 1'b1;
    stim_rows[stim_rows.size() - 1].want  = '{y_re, y_im, '0, 1'b1};
  endtask

  task automatic build_table();
    // M = 2, L = 0 clamps to 2: one output per sample.
    add_cfg(REG_TAP_COUNT, 7'd2);
    add_cfg(REG_BLOCK_LENGTH, 7'd0);
    add_checked(16'sd32767, -16'sd32768, '0, '0);                 // taps still zero
    add_word(REQ_TAP, 6'd0, -16'sd32768, -16'sd32768);
    add_word(REQ_RESTART, 6'd0, 16'sd1, 16'sd1);
    add_checked(-16'sd32768, -16'sd32768, '0, 39'sd2147483648);   // largest product
    add_checked(16'sd32767, 16'sd32767, '0, -39'sd2147418112);
    add_word(REQ_TAP, 6'd1, 16'sd32767, -16'sd32768);
    add_word(REQ_TAP, 6'd63, 16'sd1234, -16'sd1);                 // beyond M
    add_word(REQ_UNKNOWN, 6'd63, -16'sd1, -16'sd1);
    add_word(REQ_SAMPLE, 6'd0, 16'sd0, 16'sd0);
    add_word(REQ_SAMPLE, 6'd42, -16'sd1, 16'sd1);
    add_cfg(REG_UNUSED, 7'd127);                                   // keeps history
    add_word(REQ_SAMPLE, 6'd0, 16'sd12345, -16'sd23456);
    // M = 127 clamps to 64, L = 1 is raised to 64: one output per sample.
    add_cfg(REG_TAP_COUNT, 7'd127);
    add_cfg(REG_BLOCK_LENGTH, 7'd1);
    add_word(REQ_TAP, 6'd63, -16'sd32768, 16'sd32767);
    add_word(REQ_SAMPLE, 6'd0, 16'sd32767, -16'sd32768);
    add_word(REQ_SAMPLE, 6'd0, -16'sd32768, 16'sd32767);
    // M = 0 clamps to 1, L = 3: three outputs per block.
    add_cfg(REG_TAP_COUNT, 7'd0);
    add_cfg(REG_BLOCK_LENGTH, 7'd3);
    add_word(REQ_SAMPLE, 6'd0, 16'sd100, -16'sd100);
    add_word(REQ_TAP, 6'd0, 16'sd32767, 16'sd32767);               // mid-block load
    add_word(REQ_SAMPLE, 6'd0, -16'sd32768, 16'sd0);
    add_word(REQ_SAMPLE, 6'd0, 16'sd0, -16'sd32768);
    add_word(REQ_SAMPLE, 6'd0, 16'sd5, 16'sd5);
    add_word(REQ_RESTART, 6'd0, 16'sd0, 16'sd0);                   // drops the fill
    add_word(REQ_SAMPLE, 6'd0, 16'sd7, -16'sd7);
    add_word(REQ_SAMPLE, 6'd0, -16'sd9, 16'sd9);
    add_word(REQ_SAMPLE, 6'd0, 16'sd11, 16'sd13);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned m, b, n_words, phase_words;
    logic [CFG_W-1:0] tc, bl;
    int r;

    for (int j = 0; j < MAX_TAPS_DEF; j++) begin
      tap_re[j] = '0;
      tap_im[j] = '0;
    end
    clear_window();
    tap_count_reg = RESET_TAP_COUNT;
    block_len_reg = RESET_BLOCK_LENGTH;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, paced like the first random phase
    tx_idle_pct = 26;
    rx_idle_pct = 54;
    build_table();
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_data);
      end else begin
        send_word(stim_rows[i].req, stim_rows[i].idx, stim_rows[i].v_re, stim_rows[i].v_im);
        // typed rows replace the model's word with the one from the table
        if (stim_rows[i].typed)
          pending_outputs[pending_outputs.size() - 1] = stim_rows[i].want;
      end
    end

    // random blocks: phase 0 slow receiver, phase 1 slow sender, phase 2 full rate
    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 26 : (phase == 1) ? 54 : 0;
      rx_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 26 : 0;
      phase_words = 0;
      while (phase_words < PHASE_WORDS) begin
        case ($urandom_range(0, 7))
          0: begin tc = 7'd64; bl = 7'd64; end
          1: begin tc = 7'd1;  bl = 7'd64; end
          2: begin tc = CFG_W'($urandom); bl = CFG_W'($urandom); end
          default: begin
            tc = CFG_W'($urandom_range(1, 8));
            bl = tc + CFG_W'($urandom_range(0, 6));
          end
        endcase
        if ($urandom_range(0, 1)) begin
          write_reg(REG_TAP_COUNT, tc);
          write_reg(REG_BLOCK_LENGTH, bl);
        end else begin
          write_reg(REG_BLOCK_LENGTH, bl);
          write_reg(REG_TAP_COUNT, tc);
        end
        m = taps_in_use();
        b = window_len(m) - m + 1;
        for (int unsigned k = 0; k < m && phase_words < PHASE_WORDS; k++) begin
          send_word(REQ_TAP, TAP_IDX_W'(k), rand_value(), rand_value());
          phase_words++;
        end
        // B + 20 words, mostly samples, with some noise mixed in
        n_words = 20 + b;
        for (int unsigned i = 0; i < n_words && phase_words < PHASE_WORDS; i++) begin
          r = $urandom_range(0, 99);
          if (r < 80) begin
            send_word(REQ_SAMPLE, TAP_IDX_W'($urandom), rand_value(), rand_value());
          end else if (r < 88) begin
            send_word(REQ_TAP, TAP_IDX_W'($urandom), rand_value(), rand_value());
          end else if (r < 94) begin
            send_word(REQ_RESTART, TAP_IDX_W'($urandom), rand_value(), rand_value());
          end else if (r < 97) begin
            send_word(REQ_UNKNOWN, TAP_IDX_W'($urandom), rand_value(), rand_value());
            continue;  // ignored by the block, not counted
          end else begin
            send_word(REQ_SAMPLE, '0, (r[0] ? -16'sd32768 : 16'sd32767),
                      (r[1] ? -16'sd32768 : 16'sd32767));
          end
          phase_words++;
        end
      end
    end

    // drain, then give any stray word time to show up
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);

    $display("Run covered %0d input words (%0d samples), %0d output words checked,",
             in_words, sample_words, out_words);
    $display("%0d register writes across three pacing phases; %0d mismatching fields",
             cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
